[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
// Every macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/uvt_pkg.sv]
`timescale 1ns / 1ps

package uvt_pkg;

  // Field widths of the request and response items.
  localparam int REQ_W    = 2;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 11;

  // Default table capacity.
  localparam int DEF_CAPACITY = 1024;

  // Request codes. Code 3 is unused and is answered without any change.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // Response status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_WRITE,
    S_RESP
  } state_e;

  // One response item as it travels from the sequencer to the output register.
  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [CNT_W-1:0]   count;
  } res_t;

endpackage

[hw/rtl/uvt_mem.sv]
`timescale 1ns / 1ps

module uvt_mem import uvt_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int AW    = $clog2(DEF_CAPACITY),
  parameter int DW    = VAL_W
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Single read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/uvt_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uvt_ctrl import uvt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int IW       = $clog2(DEF_CAPACITY),
  parameter int CW       = $clog2(DEF_CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Request side.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic signed [VAL_W-1:0] value_i,
  // Memory port.
  output logic                    mem_we_o,
  output logic [IW-1:0]           mem_waddr_o,
  output logic [VAL_W-1:0]        mem_wdata_o,
  output logic                    mem_re_o,
  output logic [IW-1:0]           mem_raddr_o,
  input  logic [VAL_W-1:0]        mem_rdata_i,
  // Response toward the output register.
  output logic                    res_valid_o,
  input  logic                    res_stall_i,
  output res_t                    res_o
);

  state_e            state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [VAL_W-1:0]  key_q, key_d;
  logic              del_q, del_d;
  status_e           status_q, status_d;

  logic              accept;
  logic              cnt_full;
  logic              cnt_empty;
  logic [IW-1:0]     last_idx;
  logic              hit;
  logic              at_last;

  // Conditions shared by the sequencer and the datapath.
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign cnt_full  = (cnt_q == CW'(CAPACITY));
  assign cnt_empty = (cnt_q == '0);
  assign last_idx  = IW'(cnt_q - CW'(1));
  assign hit       = (mem_rdata_i == key_q);
  assign at_last   = (idx_q == last_idx);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((req_type_i inside {REQ_SEARCH, REQ_DELETE}) && !cnt_empty) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = del_q ? S_MOVE : S_RESP;
        end else if (at_last) begin
          state_d = S_RESP;
        end
      end
      S_MOVE:  state_d = S_WRITE;
      S_WRITE: state_d = S_RESP;
      S_RESP: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake and memory port outputs.
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    res_valid_o = (state_q == S_RESP);
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    case (state_q)
      S_IDLE: begin
        // An insert writes at the fill position; a scan starts by reading entry zero.
        mem_we_o    = accept && (req_type_i == REQ_INSERT) && !cnt_full;
        mem_waddr_o = IW'(cnt_q);
        mem_wdata_o = $unsigned(value_i);
        mem_re_o    = accept;
        mem_raddr_o = '0;
      end
      S_SCAN: begin
        // Read one entry ahead of the one being compared.
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q + IW'(1);
      end
      S_MOVE: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = last_idx;
      end
      S_WRITE: begin
        // The last entry fills the hole left by the deleted one.
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = mem_rdata_i;
      end
      default: begin
      end
    endcase
  end

  // Datapath register updates.
  always_comb begin
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    key_d    = key_q;
    del_d    = del_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d    = $unsigned(value_i);
          del_d    = (req_type_i == REQ_DELETE);
          idx_d    = '0;
          status_d = ST_OK;
          case (req_type_i)
            REQ_INSERT: begin
              if (cnt_full) begin
                status_d = ST_FULL;
              end else begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            REQ_SEARCH, REQ_DELETE: begin
              if (cnt_empty) begin
                status_d = ST_NOTFOUND;
              end
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          status_d = ST_OK;
        end else if (at_last) begin
          status_d = ST_NOTFOUND;
          idx_d    = '0;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_WRITE: cnt_d = cnt_q - CW'(1);
      default: begin
      end
    endcase
  end

  // Control state is reset; the key and status are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      del_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      del_q   <= del_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
  end

  // Response fields at the port widths.
  assign res_o.status   = status_q;
  assign res_o.position = POS_W'(idx_q);
  assign res_o.count    = CNT_W'(cnt_q);

  `ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(CAPACITY), "fill count exceeds capacity")
  `ASSERT_ALWAYS(a_scan_in_range, (state_q != S_SCAN) || (CW'(idx_q) < cnt_q),
                 "scan index beyond stored entries")
  `ASSERT_ALWAYS(a_no_write_in_scan, !((state_q == S_SCAN || state_q == S_MOVE) && mem_we_o),
                 "memory written during a scan")
  `ASSERT_NEXT(a_delete_shrinks, state_q == S_WRITE, cnt_q == $past(cnt_q) - CW'(1),
               "delete did not shrink the count by one")

endmodule

[hw/rtl/unordered_value_table.sv]
`timescale 1ns / 1ps

// Unordered table of up to CAPACITY signed 32-bit values with insert, search
// and delete-first-occurrence requests, one response item per request item. The
// block takes one request at a time: in_stall_o stays high from acceptance until
// the response has moved into the output register. An insert, an unused request
// code, or a search or delete on an empty table goes straight to the response
// state. Otherwise the request scans from entry zero to the first match or the
// last entry, and a matching delete moves the last entry into the hole. The scan
// reads one entry per cycle through the single read port of the entry memory and
// compares it with one 32-bit comparator. The output register lets the next
// request be accepted while a response is still waiting to be taken. Entries
// need no clearing after reset, since only entries below the fill count are used.
module unordered_value_table import uvt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [REQ_W-1:0]        req_type_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [POS_W-1:0]        position_o,
  output logic [CNT_W-1:0]        count_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  logic             res_valid;
  logic             res_stall;
  res_t             res;

  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;
  logic             load;

  uvt_mem #(
    .DEPTH (CAPACITY),
    .AW    (IW),
    .DW    (VAL_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  uvt_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res)
  );

  // Output register: takes a response when empty or when its item leaves.
  assign res_stall   = out_valid_q && out_stall_i;
  assign load        = res_valid && !res_stall;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign position_o  = out_res_q.position;
  assign count_o     = out_res_q.count;

endmodule
